// File: hdl/rlid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlid_pkg
// Shared types and constants of the line run-length image decoder: field
// widths, configuration register indexes and the structs between modules.
// ----------------------------------------------------------------------------
package rlid_pkg;

  localparam int GROUP_PIXELS   = 8;
  localparam int PIX_W          = 7;
  localparam int LANE_W         = 3;
  localparam int TAKE_W         = 4;
  localparam int BYTE_W         = 8;
  localparam int COL_W          = 10;
  localparam int ROW_W          = 10;
  localparam int GPL_W          = 7;
  localparam int ADDR_W         = 17;
  localparam int GROUP_W        = GROUP_PIXELS * PIX_W;
  localparam int CFG_DATA_W     = 10;
  localparam int CFG_INDEX_W    = 1;
  localparam int MAX_LINE_WIDTH = 512;
  localparam int MAX_LINES      = 1023;

  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_COUNT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] LINE_WIDTH_RST = 10'd384;
  localparam logic [CFG_DATA_W-1:0] LINE_COUNT_RST = 10'd280;

  localparam int RUN_FLAG_BIT = 7;

  // effective image size as the datapath uses it
  typedef struct packed {
    logic [COL_W-1:0] width;
    logic [GPL_W-1:0] gpl;
    logic [ROW_W-1:0] lines;
  } size_t;

  // one step of the group unit
  typedef struct packed {
    logic [ADDR_W-1:0]       addr;
    logic [GROUP_W-1:0]      group;
    logic [GROUP_PIXELS-1:0] mask;
    logic [COL_W-1:0]        col_next;
    logic [COL_W-1:0]        rem_next;
    logic                    line_end;
  } step_t;

endpackage
`default_nettype wire

// File: hdl/rlid_step_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlid_step_unit
// Shared group unit: from the current column, pixels left and color it forms
// one aligned 8-pixel group, its lane mask and address, and the advanced
// column and remaining count.
// ----------------------------------------------------------------------------
module rlid_step_unit (
  input  wire logic [rlid_pkg::COL_W-1:0]  col,
  input  wire logic [rlid_pkg::COL_W-1:0]  rem,
  input  wire logic [rlid_pkg::PIX_W-1:0]  color,
  input  wire logic [rlid_pkg::ADDR_W-1:0] row_base,
  input  wire rlid_pkg::size_t             size,
  output rlid_pkg::step_t                  step
);

  logic [rlid_pkg::LANE_W-1:0] lane;
  logic [rlid_pkg::TAKE_W-1:0] room;
  logic [rlid_pkg::TAKE_W-1:0] take;
  logic [rlid_pkg::TAKE_W:0]   lane_end;

  always_comb begin
    lane     = col[rlid_pkg::LANE_W-1:0];
    room     = rlid_pkg::TAKE_W'(rlid_pkg::GROUP_PIXELS) - {1'b0, lane};
    take     = ({{(rlid_pkg::COL_W-rlid_pkg::TAKE_W){1'b0}}, room} > rem)
             ? rem[rlid_pkg::TAKE_W-1:0] : room;
    lane_end = {2'b00, lane} + {1'b0, take};
    for (int i = 0; i < rlid_pkg::GROUP_PIXELS; i++) begin
      step.mask[i] = (i >= int'(lane)) && (i < int'(lane_end));
      step.group[i*rlid_pkg::PIX_W +: rlid_pkg::PIX_W] =
        step.mask[i] ? color : '0;
    end
    step.addr     = row_base
                  + {{(rlid_pkg::ADDR_W-rlid_pkg::COL_W+rlid_pkg::LANE_W){1'b0}},
                     col[rlid_pkg::COL_W-1:rlid_pkg::LANE_W]};
    step.col_next = col + {{(rlid_pkg::COL_W-rlid_pkg::TAKE_W){1'b0}}, take};
    step.rem_next = rem - {{(rlid_pkg::COL_W-rlid_pkg::TAKE_W){1'b0}}, take};
    step.line_end = step.col_next >= size.width;
  end

endmodule
`default_nettype wire

// File: hdl/rlid_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlid_ctrl
// Sequencer of the decoder: decodes code bytes, keeps column, row and run
// state, drives the group unit once per group and holds the output register.
// ----------------------------------------------------------------------------
module rlid_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [rlid_pkg::BYTE_W-1:0]       in_code_byte,
  input  wire rlid_pkg::size_t                   size,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [rlid_pkg::ADDR_W-1:0]            out_word_address,
  output logic [rlid_pkg::GROUP_W-1:0]           out_pixel_group,
  output logic [rlid_pkg::GROUP_PIXELS-1:0]      out_byte_mask,
  output logic                                   out_run_last,
  output logic                                   out_image_done
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_NORM = 4'b0010,
    S_BASE = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [rlid_pkg::COL_W-1:0]      col_r, col_nxt;
  logic [rlid_pkg::ROW_W-1:0]      row_r, row_nxt;
  logic [rlid_pkg::ADDR_W-1:0]     base_r, base_nxt;
  logic [rlid_pkg::COL_W-1:0]      rem_r, rem_nxt;
  logic [rlid_pkg::PIX_W-1:0]      color_r, color_nxt;
  logic [rlid_pkg::PIX_W-1:0]      held_r, held_nxt;
  logic                            await_r, await_nxt;
  logic [rlid_pkg::BYTE_W-1:0]     byte_r, byte_nxt;
  logic                            ovalid_r, ovalid_nxt;
  logic [rlid_pkg::ADDR_W-1:0]     oaddr_r, oaddr_nxt;
  logic [rlid_pkg::GROUP_W-1:0]    ogroup_r, ogroup_nxt;
  logic [rlid_pkg::GROUP_PIXELS-1:0] omask_r, omask_nxt;
  logic                            olast_r, olast_nxt;
  logic                            odone_r, odone_nxt;

  rlid_pkg::step_t                 step;
  logic [rlid_pkg::COL_W-1:0]      col_n;
  logic [rlid_pkg::ROW_W-1:0]      row_n;
  logic [rlid_pkg::COL_W-1:0]      avail;
  logic [rlid_pkg::ROW_W-1:0]      row_inc;
  logic                            in_acc;
  logic                            out_free;

  rlid_step_unit u_step (
    .col      (col_r),
    .rem      (rem_r),
    .color    (color_r),
    .row_base (base_r),
    .size     (size),
    .step     (step)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !ovalid_r || out_ready;

  always_comb begin
    col_n   = (col_r >= size.width) ? '0 : col_r;
    row_n   = (row_r >= size.lines) ? '0 : row_r;
    avail   = size.width - col_n;
    row_inc = row_r + 1'b1;

    state_nxt  = state_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    base_nxt   = base_r;
    rem_nxt    = rem_r;
    color_nxt  = color_r;
    held_nxt   = held_r;
    await_nxt  = await_r;
    byte_nxt   = byte_r;
    ovalid_nxt = ovalid_r && !out_ready;
    oaddr_nxt  = oaddr_r;
    ogroup_nxt = ogroup_r;
    omask_nxt  = omask_r;
    olast_nxt  = olast_r;
    odone_nxt  = odone_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!await_r && in_code_byte[rlid_pkg::RUN_FLAG_BIT]) begin
            held_nxt  = in_code_byte[rlid_pkg::PIX_W-1:0];
            await_nxt = 1'b1;
          end else begin
            byte_nxt  = in_code_byte;
            state_nxt = S_NORM;
          end
        end
      end
      S_NORM: begin
        col_nxt   = col_n;
        row_nxt   = row_n;
        await_nxt = 1'b0;
        if (await_r) begin
          color_nxt = held_r;
          rem_nxt   = (byte_r != '0 && {2'b00, byte_r} < avail) ? {2'b00, byte_r} : avail;
        end else begin
          color_nxt = byte_r[rlid_pkg::PIX_W-1:0];
          rem_nxt   = rlid_pkg::COL_W'(1);
        end
        state_nxt = S_BASE;
      end
      S_BASE: begin
        base_nxt  = rlid_pkg::ADDR_W'(
                      {{(rlid_pkg::ADDR_W-rlid_pkg::ROW_W){1'b0}}, row_r}
                    * {{(rlid_pkg::ADDR_W-rlid_pkg::GPL_W){1'b0}}, size.gpl});
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          oaddr_nxt  = step.addr;
          ogroup_nxt = step.group;
          omask_nxt  = step.mask;
          olast_nxt  = (step.rem_next == '0);
          odone_nxt  = 1'b0;
          rem_nxt    = step.rem_next;
          col_nxt    = step.col_next;
          if (step.line_end) begin
            col_nxt = '0;
            if (row_inc >= size.lines) begin
              row_nxt   = '0;
              base_nxt  = '0;
              odone_nxt = 1'b1;
            end else begin
              row_nxt  = row_inc;
              base_nxt = base_r
                       + {{(rlid_pkg::ADDR_W-rlid_pkg::GPL_W){1'b0}}, size.gpl};
            end
          end
          if (step.rem_next == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      col_r    <= '0;
      row_r    <= '0;
      held_r   <= '0;
      await_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      held_r   <= held_nxt;
      await_r  <= await_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r   <= base_nxt;
    rem_r    <= rem_nxt;
    color_r  <= color_nxt;
    byte_r   <= byte_nxt;
    oaddr_r  <= oaddr_nxt;
    ogroup_r <= ogroup_nxt;
    omask_r  <= omask_nxt;
    olast_r  <= olast_nxt;
    odone_r  <= odone_nxt;
  end

  assign out_valid        = ovalid_r;
  assign out_word_address = oaddr_r;
  assign out_pixel_group  = ogroup_r;
  assign out_byte_mask    = omask_r;
  assign out_run_last     = olast_r;
  assign out_image_done   = odone_r;

endmodule
`default_nettype wire

// File: hdl/line_run_length_image_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_run_length_image_decoder_core
// Run-length decoder for a 7-bit palette image, writing aligned 8-pixel
// groups with a byte mask and frame word address.
// ----------------------------------------------------------------------------
// One code byte is taken at a time. A run marker gives no word and leaves
// in_ready high. A literal or count byte goes through the setup states NORM
// (position clamp and run length) and BASE (row base multiply) and then gives
// one word per cycle, while the output is not stalled, from the shared group
// unit; in_ready stays low until its last word is loaded into the output
// register. A run is clipped at the end of its line and a zero count fills the
// line. Line width and line count are written through cfg_we, cfg_index,
// cfg_data; the user must write them only while the block is idle, which the block itself does not enforce.
module line_run_length_image_decoder_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [rlid_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [rlid_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [rlid_pkg::BYTE_W-1:0]           in_code_byte,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [rlid_pkg::ADDR_W-1:0]                out_word_address,
  output logic [rlid_pkg::GROUP_W-1:0]               out_pixel_group,
  output logic [rlid_pkg::GROUP_PIXELS-1:0]          out_byte_mask,
  output logic                                       out_run_last,
  output logic                                       out_image_done
);

  logic [rlid_pkg::CFG_DATA_W-1:0] width_cfg_r;
  logic [rlid_pkg::CFG_DATA_W-1:0] lines_cfg_r;
  logic [rlid_pkg::COL_W-1:0]      width_al;
  rlid_pkg::size_t                 size;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r <= rlid_pkg::LINE_WIDTH_RST;
      lines_cfg_r <= rlid_pkg::LINE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlid_pkg::CFG_LINE_WIDTH: width_cfg_r <= cfg_data;
        rlid_pkg::CFG_LINE_COUNT: lines_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective size: width rounded down to whole groups and clamped to 8..512, zero line count read as one
  always_comb begin
    width_al = {width_cfg_r[rlid_pkg::COL_W-1:rlid_pkg::LANE_W], {rlid_pkg::LANE_W{1'b0}}};
    if (width_al == '0) begin
      size.width = rlid_pkg::COL_W'(rlid_pkg::GROUP_PIXELS);
    end else if (width_al > rlid_pkg::COL_W'(rlid_pkg::MAX_LINE_WIDTH)) begin
      size.width = rlid_pkg::COL_W'(rlid_pkg::MAX_LINE_WIDTH);
    end else begin
      size.width = width_al;
    end
    size.gpl   = size.width[rlid_pkg::LANE_W +: rlid_pkg::GPL_W];
    size.lines = (lines_cfg_r == '0) ? rlid_pkg::ROW_W'(1) : lines_cfg_r;
  end

  rlid_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_code_byte     (in_code_byte),
    .size             (size),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_word_address (out_word_address),
    .out_pixel_group  (out_pixel_group),
    .out_byte_mask    (out_byte_mask),
    .out_run_last     (out_run_last),
    .out_image_done   (out_image_done)
  );

  // every word writes at least one pixel
  a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_mask != '0))
    else $error("word with empty byte mask");

  // the last line ends exactly where a byte's painting ends
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_image_done) |-> out_run_last)
    else $error("image done on a word that is not the last of its byte");

  // a completed image restarts at word address zero
  a_wrap_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_image_done) |=> !out_valid || out_word_address == '0
      || !$past(out_run_last))
    else $error("position did not wrap after image done");

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the line run-length image decoder core. Code bytes
// are driven from a queue through a valid/ready driver with random idle
// bursts. Each accepted byte is decoded by a local model of the run-length
// scheme that predicts the 8-pixel words it paints. A monitor compares every
// accepted word field by field with the oldest prediction. Line width and
// line count are changed between phases while the core is idle, including
// zero, odd and oversized values.
// ----------------------------------------------------------------------------
module tb;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [rlid_pkg::ADDR_W-1:0]       addr;
    logic [rlid_pkg::GROUP_W-1:0]      pixels;
    logic [rlid_pkg::GROUP_PIXELS-1:0] mask;
    logic                              run_last;
    logic                              image_done;
  } group_word_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  logic [rlid_pkg::CFG_INDEX_W-1:0]  cfg_index = rlid_pkg::CFG_LINE_WIDTH;
  logic [rlid_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [rlid_pkg::BYTE_W-1:0]       in_code_byte = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [rlid_pkg::ADDR_W-1:0]       out_word_address;
  logic [rlid_pkg::GROUP_W-1:0]      out_pixel_group;
  logic [rlid_pkg::GROUP_PIXELS-1:0] out_byte_mask;
  logic                              out_run_last;
  logic                              out_image_done;

  logic [rlid_pkg::BYTE_W-1:0] pending_bytes[$];
  group_word_t                 expected_groups[$];
  int                          error_count = 0;
  int                          stall_cycles = 0;
  bit                          idle_on = 1'b1;
  int                          send_gap = 0;
  int                          ready_gap = 0;

  // decoder state
  logic [rlid_pkg::CFG_DATA_W-1:0] width_reg = rlid_pkg::LINE_WIDTH_RST;
  logic [rlid_pkg::CFG_DATA_W-1:0] lines_reg = rlid_pkg::LINE_COUNT_RST;
  int                              pos_col = 0;
  int                              pos_row = 0;
  bit                              count_pending = 1'b0;
  logic [rlid_pkg::PIX_W-1:0]      run_color = '0;

  line_run_length_image_decoder_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_code_byte     (in_code_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_word_address (out_word_address),
    .out_pixel_group  (out_pixel_group),
    .out_byte_mask    (out_byte_mask),
    .out_run_last     (out_run_last),
    .out_image_done   (out_image_done)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int eff_width();
    int w;
    w = int'(width_reg & 10'h3F8);
    if (w == 0) w = rlid_pkg::GROUP_PIXELS;
    if (w > rlid_pkg::MAX_LINE_WIDTH) w = rlid_pkg::MAX_LINE_WIDTH;
    return w;
  endfunction

  function automatic int eff_lines();
    int n;
    n = int'(lines_reg);
    if (n == 0) n = 1;
    if (n > rlid_pkg::MAX_LINES) n = rlid_pkg::MAX_LINES;
    return n;
  endfunction

  function automatic void paint_groups(input logic [rlid_pkg::PIX_W-1:0] color,
                                       input int npix);
    int w;
    int nl;
    int remaining;
    int lane;
    int take;
    group_word_t g;
    w = eff_width();
    nl = eff_lines();
    remaining = npix;
    while (remaining > 0) begin
      lane = pos_col % rlid_pkg::GROUP_PIXELS;
      take = rlid_pkg::GROUP_PIXELS - lane;
      if (take > remaining) take = remaining;
      g = '0;
      for (int i = lane; i < lane + take; i++) begin
        g.pixels[rlid_pkg::PIX_W*i +: rlid_pkg::PIX_W] = color;
        g.mask[i] = 1'b1;
      end
      g.addr = rlid_pkg::ADDR_W'(pos_row * (w / rlid_pkg::GROUP_PIXELS)
                                 + pos_col / rlid_pkg::GROUP_PIXELS);
      pos_col += take;
      remaining -= take;
      if (pos_col >= w) begin
        pos_col = 0;
        pos_row++;
        if (pos_row >= nl) begin
          pos_row = 0;
          g.image_done = 1'b1;
        end
      end
      g.run_last = (remaining == 0);
      expected_groups.push_back(g);
    end
  endfunction

  function automatic void decode_byte(input logic [rlid_pkg::BYTE_W-1:0] b);
    int w;
    int npix;
    if (!count_pending && b[rlid_pkg::RUN_FLAG_BIT]) begin
      run_color = b[rlid_pkg::PIX_W-1:0];
      count_pending = 1'b1;
      return;
    end
    w = eff_width();
    if (pos_col >= w) pos_col = 0;
    if (pos_row >= eff_lines()) pos_row = 0;
    if (count_pending) begin
      count_pending = 1'b0;
      npix = w - pos_col;
      if (b != 0 && int'(b) < npix) npix = int'(b);
      paint_groups(run_color, npix);
    end else begin
      paint_groups(b[rlid_pkg::PIX_W-1:0], 1);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) decode_byte(in_code_byte);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        if (idle_on && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 13);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_code_byte <= pending_bytes.pop_front();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    group_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_groups.size() == 0) begin
          report_mismatch("word with nothing expected, address", out_word_address, '0);
        end else begin
          want = expected_groups.pop_front();
          if (out_word_address !== want.addr)
            report_mismatch("word_address", out_word_address, want.addr);
          if (out_pixel_group !== want.pixels)
            report_mismatch("pixel_group", out_pixel_group, want.pixels);
          if (out_byte_mask !== want.mask)
            report_mismatch("byte_mask", out_byte_mask, want.mask);
          if (out_run_last !== want.run_last)
            report_mismatch("run_last", out_run_last, want.run_last);
          if (out_image_done !== want.image_done)
            report_mismatch("image_done", out_image_done, want.image_done);
        end
      end
      if (ready_gap > 0) begin
        ready_gap--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        ready_gap = $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [rlid_pkg::CFG_INDEX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= rlid_pkg::CFG_DATA_W'(value);
    if (idx == rlid_pkg::CFG_LINE_WIDTH) width_reg = rlid_pkg::CFG_DATA_W'(value);
    else lines_reg = rlid_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_size(input int width, input int lines);
    write_reg(rlid_pkg::CFG_LINE_WIDTH, width);
    write_reg(rlid_pkg::CFG_LINE_COUNT, lines);
  endtask

  // sampled away from the rising edge so driver updates have settled
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid || expected_groups.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_random_items(input int count);
    int sel;
    int c;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        pending_bytes.push_back({1'b0, 7'($urandom_range(0, 127))});
      end else if (sel < 9) begin
        pending_bytes.push_back({1'b1, 7'($urandom_range(0, 127))});
        c = $urandom_range(0, 19);
        if (c < 3) pending_bytes.push_back(8'h00);
        else if (c < 6) pending_bytes.push_back(8'($urandom_range(21, 255)));
        else pending_bytes.push_back(8'($urandom_range(1, 20)));
      end else begin
        pending_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int widths[8];
    int heights[8];
    widths  = '{16, 0, 13, 1023, 512, 64, 384, 40};
    heights = '{2, 0, 3, 1023, 1, 1000, 280, 3};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset size: literal extremes, fill to line end, long counts
    pending_bytes = '{8'h00, 8'h7F, 8'h80, 8'h01, 8'hFF, 8'h00, 8'h81, 8'hFF,
                      8'h82, 8'h80, 8'h2A};
    wait_idle();

    // narrow two-line image: clipped runs, fill and image wrap
    set_size(16, 2);
    pending_bytes = '{8'h55, 8'h85, 8'h14, 8'h86, 8'h00, 8'h01, 8'h87, 8'h03,
                      8'h88, 8'h0D};
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      idle_on = (p != 5 && p != 7);
      set_size(widths[p], heights[p]);
      add_random_items(27);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
